/* rtl/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, phase codes and request codes for the traffic phase controller.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int unsigned PHASE_W   = 2;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned CODE_W    = 4;
    localparam int unsigned S_DATA_W  = 8;
    localparam int unsigned M_DATA_W  = 8;

    localparam logic [PHASE_W-1:0] PH_MAIN_STRAIGHT = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MAIN_TURN     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SIDE_STRAIGHT = 2'd2;
    localparam logic [PHASE_W-1:0] PH_SIDE_TURN     = 2'd3;

    localparam logic [PHASE_W-1:0] CH_NONE  = 2'd0;
    localparam logic [PHASE_W-1:0] CH_FIRST = 2'd1;
    localparam logic [PHASE_W-1:0] CH_SECOND = 2'd2;
    localparam logic [PHASE_W-1:0] CH_THIRD = 2'd3;

    localparam logic [CODE_W-1:0] REQ_MAIN_TURN_A     = 4'd12;
    localparam logic [CODE_W-1:0] REQ_MAIN_TURN_B     = 4'd11;
    localparam logic [CODE_W-1:0] REQ_SIDE_STRAIGHT_A = 4'd10;
    localparam logic [CODE_W-1:0] REQ_SIDE_STRAIGHT_B = 4'd9;
    localparam logic [CODE_W-1:0] REQ_SIDE_TURN_A     = 4'd8;
    localparam logic [CODE_W-1:0] REQ_SIDE_TURN_B     = 4'd7;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'hFF;
    localparam logic [COUNT_W-1:0] MIN_GREEN_RESET = 8'd10;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [COUNT_W-1:0] elapsed;
        logic [PHASE_W-1:0] pending;
    } tpc_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0] next_light_code;
        logic               phase_changed;
        logic [PHASE_W-1:0] light_code;
    } tpc_result_t;

    function automatic logic [PHASE_W-1:0] next_phase(
        input logic [PHASE_W-1:0] cur,
        input logic [PHASE_W-1:0] choice
    );
        logic [PHASE_W-1:0] res;
        res = PH_MAIN_STRAIGHT;
        case (cur)
            PH_MAIN_STRAIGHT:
            begin
                res = choice;
            end
            PH_MAIN_TURN:
            begin
                case (choice)
                    CH_FIRST:  res = PH_SIDE_STRAIGHT;
                    CH_SECOND: res = PH_SIDE_TURN;
                    CH_THIRD:  res = PH_MAIN_STRAIGHT;
                    default:   res = PH_MAIN_TURN;
                endcase
            end
            PH_SIDE_STRAIGHT:
            begin
                case (choice)
                    CH_NONE:  res = PH_SIDE_STRAIGHT;
                    CH_FIRST: res = PH_SIDE_TURN;
                    default:  res = PH_MAIN_STRAIGHT;
                endcase
            end
            default:
            begin
                res = (choice == CH_NONE) ? PH_SIDE_TURN : PH_MAIN_STRAIGHT;
            end
        endcase
        return res;
    endfunction

endpackage

/* rtl/tpc_step.sv */
// ----------------------------------------------------------------------------
// tpc_step
// One tick of the phase controller: count, latch request, decide phase change.
// ----------------------------------------------------------------------------
module tpc_step
(
    input  tpc_pkg::tpc_state_t          cur_state,
    input  logic [tpc_pkg::CODE_W-1:0]   request_code,
    input  logic [tpc_pkg::COUNT_W-1:0]  min_green,
    output tpc_pkg::tpc_state_t          new_state,
    output tpc_pkg::tpc_result_t         result
);
    import tpc_pkg::*;

    logic [COUNT_W-1:0] elapsed_inc;
    logic [PHASE_W-1:0] pend;
    logic               req_mt;
    logic               req_ss;
    logic               req_st;
    logic               switch_now;
    logic [PHASE_W-1:0] target;

    always_comb
    begin
        req_mt = request_code inside {REQ_MAIN_TURN_A, REQ_MAIN_TURN_B};
        req_ss = request_code inside {REQ_SIDE_STRAIGHT_A, REQ_SIDE_STRAIGHT_B};
        req_st = request_code inside {REQ_SIDE_TURN_A, REQ_SIDE_TURN_B};

        elapsed_inc = (cur_state.elapsed == COUNT_MAX) ? COUNT_MAX
                                                        : cur_state.elapsed + 8'd1;

        pend = cur_state.pending;
        case (cur_state.phase)
            PH_MAIN_STRAIGHT:
            begin
                if (req_mt)
                    pend = CH_FIRST;
                else if (req_ss && pend != CH_FIRST)
                    pend = CH_SECOND;
                else if (req_st && pend != CH_FIRST && pend != CH_SECOND)
                    pend = CH_THIRD;
            end
            PH_MAIN_TURN:
            begin
                if (req_ss)
                    pend = CH_FIRST;
                else if (req_st && pend != CH_FIRST)
                    pend = CH_SECOND;
                else if (pend == CH_NONE)
                    pend = CH_THIRD;
            end
            PH_SIDE_STRAIGHT:
            begin
                if (req_st)
                    pend = CH_FIRST;
                else if (pend != CH_FIRST)
                    pend = CH_SECOND;
            end
            default:
            begin
                if (pend == CH_NONE)
                    pend = CH_FIRST;
            end
        endcase

        switch_now = (elapsed_inc >= min_green) && (pend != CH_NONE);
        target     = next_phase(cur_state.phase, pend);

        if (switch_now)
        begin
            new_state.phase   = target;
            new_state.elapsed = '0;
            new_state.pending = CH_NONE;
        end
        else
        begin
            new_state.phase   = cur_state.phase;
            new_state.elapsed = elapsed_inc;
            new_state.pending = pend;
        end

        result.light_code      = cur_state.phase;
        result.phase_changed   = switch_now;
        result.next_light_code = new_state.phase;
    end

endmodule

/* rtl/traffic_phase_controller_unit.sv */
// ----------------------------------------------------------------------------
// traffic_phase_controller_unit
// Four-phase traffic light controller driven by one-second tick words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one word per one-second tick, request code in
//   s_tdata[3:0]. Master stream (m_*): one word per tick giving the phase
//   shown during the tick, whether the tick ended the phase, and the phase
//   in force afterwards.
//   min_green is written through cfg_wr_en / cfg_wr_data while idle.
//   Path: a word taken is held in the input register, evaluated by
//   tpc_step, then captured in the result register that drives m_*.
//   Throughput: one word per cycle; the input register and the result
//   register each advance whenever the stage after them is free.
//   Reset: phase main straight, counter and pending choice cleared,
//   min_green 10, both streams empty.
//   Stall: while m_tready is low the result word holds, the input register
//   still fills once, then s_tready drops until the master side drains.
// ----------------------------------------------------------------------------
module traffic_phase_controller_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tpc_pkg::S_DATA_W-1:0]  s_tdata,  // [3:0] request_code
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tpc_pkg::M_DATA_W-1:0]  m_tdata,  // [1:0] light_code, [2] phase_changed,
                                                    // [4:3] next_light_code
    input  logic                          cfg_wr_en,
    input  logic [tpc_pkg::COUNT_W-1:0]   cfg_wr_data
);
    import tpc_pkg::*;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [CODE_W-1:0]   code_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    tpc_result_t         out_data_reg;
    tpc_state_t          state_reg;
    tpc_state_t          state_next;
    logic [COUNT_W-1:0]  min_green_reg;

    tpc_state_t          step_state;
    tpc_result_t         step_result;
    logic                out_free;
    logic                advance;

    tpc_step u_step
    (
        .cur_state    (state_reg),
        .request_code (code_reg),
        .min_green    (min_green_reg),
        .new_state    (step_state),
        .result       (step_result)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || m_tready;
        advance        = in_valid_reg && out_free;
        s_tready       = !in_valid_reg || advance;
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance || (out_valid_reg && !m_tready);
        state_next     = advance ? step_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_MAIN_STRAIGHT, elapsed: '0, pending: CH_NONE};
            min_green_reg <= MIN_GREEN_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            if (cfg_wr_en)
                min_green_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            code_reg <= s_tdata[CODE_W-1:0];
        if (advance)
            out_data_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(tpc_result_t)){1'b0}}, out_data_reg};

endmodule

/* tb/tb_traffic_phase_controller_unit.sv */
// ----------------------------------------------------------------------------
// tb_traffic_phase_controller_unit
// Stream-level testbench for the four-phase traffic light controller.
// A directed table covers reset behavior, every phase transition, the ignored
// request codes and min_green at 0, 1 and 255. Random phases follow, with
// varying min_green, a long quiet run into counter saturation, and
// sender/receiver idling including a long receiver hold-off. Each result
// word is checked against its typed table row or the in-bench phase model.
// ----------------------------------------------------------------------------
module tb_traffic_phase_controller_unit;

    import tpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DIR_ROWS    = 25;
    localparam int unsigned RAND_PHASES = 12;
    localparam logic [CODE_W-1:0] NO_REQ = 4'd0;

    typedef struct packed {
        bit                 wr_cfg;
        logic [COUNT_W-1:0] cfg_val;
        logic [CODE_W-1:0]  code;
        bit                 typed;
        logic [PHASE_W-1:0] light;
        logic               changed;
        logic [PHASE_W-1:0] next;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_wr_en;
    logic [COUNT_W-1:0]   cfg_wr_data;

    logic [PHASE_W-1:0]   sig_phase;
    logic [COUNT_W-1:0]   sig_elapsed;
    logic [PHASE_W-1:0]   sig_choice;
    logic [COUNT_W-1:0]   sig_min_green;

    tpc_result_t          light_words_due [$];
    dir_row_t             dir_rows [DIR_ROWS];
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;
    logic                 hold_off;
    int unsigned          mismatches;
    int unsigned          cycle_count;

    int unsigned          mode_send_pct [4] = '{0, 80, 0, 32};
    int unsigned          mode_recv_pct [4] = '{0, 0, 80, 32};
    logic [COUNT_W-1:0]   phase_min_green [RAND_PHASES] =
        '{8'd1, 8'd0, 8'd3, 8'd255, 8'd2, 8'd1, 8'd0, 8'd5, 8'd1, 8'd0, 8'd4, 8'd10};

    traffic_phase_controller_unit uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic tpc_result_t advance_signal_tick(input logic [CODE_W-1:0] code);
        tpc_result_t        word;
        logic [PHASE_W-1:0] ch;
        logic [PHASE_W-1:0] nxt;
        bit                 want_mt;
        bit                 want_ss;
        bit                 want_st;
        want_mt = (code == REQ_MAIN_TURN_A) || (code == REQ_MAIN_TURN_B);
        want_ss = (code == REQ_SIDE_STRAIGHT_A) || (code == REQ_SIDE_STRAIGHT_B);
        want_st = (code == REQ_SIDE_TURN_A) || (code == REQ_SIDE_TURN_B);
        if (sig_elapsed != COUNT_MAX)
            sig_elapsed = sig_elapsed + 8'd1;
        ch = sig_choice;
        case (sig_phase)
            PH_MAIN_STRAIGHT:
            begin
                if (want_mt)
                    ch = CH_FIRST;
                else if (want_ss && ch != CH_FIRST)
                    ch = CH_SECOND;
                else if (want_st && ch == CH_NONE)
                    ch = CH_THIRD;
            end
            PH_MAIN_TURN:
            begin
                if (want_ss)
                    ch = CH_FIRST;
                else if (want_st && ch != CH_FIRST)
                    ch = CH_SECOND;
                else if (ch == CH_NONE)
                    ch = CH_THIRD;
            end
            PH_SIDE_STRAIGHT:
            begin
                if (want_st)
                    ch = CH_FIRST;
                else if (ch != CH_FIRST)
                    ch = CH_SECOND;
            end
            default:
            begin
                if (ch == CH_NONE)
                    ch = CH_FIRST;
            end
        endcase
        word.light_code    = sig_phase;
        word.phase_changed = 1'b0;
        nxt = sig_phase;
        // min_green of 0 acts as 1 since elapsed is already incremented
        if (sig_elapsed >= sig_min_green && ch != CH_NONE)
        begin
            case (sig_phase)
                PH_MAIN_STRAIGHT:
                begin
                    case (ch)
                        CH_FIRST:  nxt = PH_MAIN_TURN;
                        CH_SECOND: nxt = PH_SIDE_STRAIGHT;
                        default:   nxt = PH_SIDE_TURN;
                    endcase
                end
                PH_MAIN_TURN:
                begin
                    case (ch)
                        CH_FIRST:  nxt = PH_SIDE_STRAIGHT;
                        CH_SECOND: nxt = PH_SIDE_TURN;
                        default:   nxt = PH_MAIN_STRAIGHT;
                    endcase
                end
                PH_SIDE_STRAIGHT:
                begin
                    nxt = (ch == CH_FIRST) ? PH_SIDE_TURN : PH_MAIN_STRAIGHT;
                end
                default:
                begin
                    nxt = PH_MAIN_STRAIGHT;
                end
            endcase
            word.phase_changed = 1'b1;
            sig_phase   = nxt;
            sig_elapsed = '0;
            sig_choice  = CH_NONE;
        end
        else
        begin
            sig_choice = ch;
        end
        word.next_light_code = nxt;
        return word;
    endfunction

    function automatic dir_row_t dir_row(
        input bit                 wr_cfg,
        input logic [COUNT_W-1:0] cfg_val,
        input logic [CODE_W-1:0]  code,
        input bit                 typed,
        input logic [PHASE_W-1:0] light,
        input logic               changed,
        input logic [PHASE_W-1:0] next
    );
        dir_row_t r;
        r.wr_cfg  = wr_cfg;
        r.cfg_val = cfg_val;
        r.code    = code;
        r.typed   = typed;
        r.light   = light;
        r.changed = changed;
        r.next    = next;
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] rand_quiet_code();
        int unsigned c;
        c = $urandom_range(9, 0);
        return (c < 7) ? c[CODE_W-1:0] : (c[CODE_W-1:0] + 4'd6);
    endfunction

    function automatic logic [CODE_W-1:0] rand_tick_code();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return CODE_W'($urandom_range(12, 7));
        else if (r < 75)
            return rand_quiet_code();
        return CODE_W'($urandom_range(15, 0));
    endfunction

    task automatic set_idle_mode(input int unsigned mode);
        send_idle_pct  = mode_send_pct[mode % 4];
        recv_stall_pct = mode_recv_pct[mode % 4];
    endtask

    task automatic send_tick(
        input logic [CODE_W-1:0] code,
        input bit                typed,
        input tpc_result_t       typed_word
    );
        int unsigned gap;
        tpc_result_t word;
        gap = 0;
        while ($urandom_range(99, 0) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-CODE_W){1'b0}}, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        word = advance_signal_tick(code);
        light_words_due.push_back(typed ? typed_word : word);
    endtask

    task automatic wait_lights_settled();
        s_tvalid <= 1'b0;
        while (light_words_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_min_green(input logic [COUNT_W-1:0] value);
        wait_lights_settled();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        sig_min_green = value;
    endtask

    // result word checker and receiver ready
    always @(posedge clk)
    begin
        tpc_result_t got;
        tpc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = tpc_result_t'(m_tdata[$bits(tpc_result_t)-1:0]);
            if (light_words_due.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected word: expected none actual %0h", $time, got);
            end
            else
            begin
                want = light_words_due.pop_front();
                if (got.light_code !== want.light_code)
                begin
                    mismatches++;
                    $display("%0t light_code: expected %0d actual %0d",
                             $time, want.light_code, got.light_code);
                end
                if (got.phase_changed !== want.phase_changed)
                begin
                    mismatches++;
                    $display("%0t phase_changed: expected %0d actual %0d",
                             $time, want.phase_changed, got.phase_changed);
                end
                if (got.next_light_code !== want.next_light_code)
                begin
                    mismatches++;
                    $display("%0t next_light_code: expected %0d actual %0d",
                             $time, want.next_light_code, got.next_light_code);
                end
            end
        end
        m_tready <= !hold_off && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        tpc_result_t tw;
        int unsigned n_items;
        int unsigned quiet_run;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        hold_off       = 1'b0;
        mismatches     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sig_phase      = PH_MAIN_STRAIGHT;
        sig_elapsed    = '0;
        sig_choice     = CH_NONE;
        sig_min_green  = MIN_GREEN_RESET;

        // after reset: no request holds main straight; 14/13/15 request nothing
        dir_rows[0]  = dir_row(0, 0, NO_REQ, 1, PH_MAIN_STRAIGHT, 0, PH_MAIN_STRAIGHT);
        dir_rows[1]  = dir_row(0, 0, 4'd15, 1, PH_MAIN_STRAIGHT, 0, PH_MAIN_STRAIGHT);
        dir_rows[2]  = dir_row(0, 0, 4'd14, 1, PH_MAIN_STRAIGHT, 0, PH_MAIN_STRAIGHT);
        dir_rows[3]  = dir_row(0, 0, 4'd13, 1, PH_MAIN_STRAIGHT, 0, PH_MAIN_STRAIGHT);
        // min_green 1: every transition of the phase table
        dir_rows[4]  = dir_row(1, 1, REQ_MAIN_TURN_A, 1, PH_MAIN_STRAIGHT, 1, PH_MAIN_TURN);
        dir_rows[5]  = dir_row(0, 0, NO_REQ, 1, PH_MAIN_TURN, 1, PH_MAIN_STRAIGHT);
        dir_rows[6]  = dir_row(0, 0, REQ_SIDE_STRAIGHT_B, 1,
                               PH_MAIN_STRAIGHT, 1, PH_SIDE_STRAIGHT);
        dir_rows[7]  = dir_row(0, 0, NO_REQ, 1, PH_SIDE_STRAIGHT, 1, PH_MAIN_STRAIGHT);
        dir_rows[8]  = dir_row(0, 0, REQ_SIDE_TURN_B, 1, PH_MAIN_STRAIGHT, 1, PH_SIDE_TURN);
        dir_rows[9]  = dir_row(0, 0, NO_REQ, 1, PH_SIDE_TURN, 1, PH_MAIN_STRAIGHT);
        dir_rows[10] = dir_row(0, 0, REQ_MAIN_TURN_B, 1, PH_MAIN_STRAIGHT, 1, PH_MAIN_TURN);
        dir_rows[11] = dir_row(0, 0, REQ_SIDE_STRAIGHT_A, 1,
                               PH_MAIN_TURN, 1, PH_SIDE_STRAIGHT);
        dir_rows[12] = dir_row(0, 0, REQ_SIDE_TURN_A, 1, PH_SIDE_STRAIGHT, 1, PH_SIDE_TURN);
        dir_rows[13] = dir_row(0, 0, 4'd5, 1, PH_SIDE_TURN, 1, PH_MAIN_STRAIGHT);
        dir_rows[14] = dir_row(0, 0, REQ_MAIN_TURN_A, 1, PH_MAIN_STRAIGHT, 1, PH_MAIN_TURN);
        dir_rows[15] = dir_row(0, 0, REQ_SIDE_TURN_B, 1, PH_MAIN_TURN, 1, PH_SIDE_TURN);
        dir_rows[16] = dir_row(0, 0, 4'd1, 1, PH_SIDE_TURN, 1, PH_MAIN_STRAIGHT);
        // min_green of zero switches on the first tick
        dir_rows[17] = dir_row(1, 0, REQ_SIDE_STRAIGHT_A, 1,
                               PH_MAIN_STRAIGHT, 1, PH_SIDE_STRAIGHT);
        dir_rows[18] = dir_row(0, 0, 4'd3, 1, PH_SIDE_STRAIGHT, 1, PH_MAIN_STRAIGHT);
        // priority latching, checked by the model
        dir_rows[19] = dir_row(1, 255, REQ_SIDE_TURN_A, 0, 0, 0, 0);
        dir_rows[20] = dir_row(0, 0, REQ_SIDE_STRAIGHT_B, 0, 0, 0, 0);
        dir_rows[21] = dir_row(1, 4, REQ_MAIN_TURN_B, 0, 0, 0, 0);
        dir_rows[22] = dir_row(0, 0, REQ_SIDE_TURN_A, 0, 0, 0, 0);
        dir_rows[23] = dir_row(0, 0, 4'd6, 0, 0, 0, 0);
        dir_rows[24] = dir_row(0, 0, 4'd2, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            set_idle_mode(i);
            if (dir_rows[i].wr_cfg)
                write_min_green(dir_rows[i].cfg_val);
            tw.light_code      = dir_rows[i].light;
            tw.phase_changed   = dir_rows[i].changed;
            tw.next_light_code = dir_rows[i].next;
            send_tick(dir_rows[i].code, dir_rows[i].typed, tw);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (phase_min_green[p] == COUNT_MAX)
            begin
                // settle back to main straight under the previous short minimum
                for (int k = 0; k < 12; k++)
                    send_tick(rand_quiet_code(), 0, tw);
            end
            if (p == 5)
            begin
                write_min_green(COUNT_W'($urandom_range(20, 1)));
            end
            else
            begin
                write_min_green(phase_min_green[p]);
            end
            set_idle_mode(p);
            n_items   = 95;
            quiet_run = 0;
            if (phase_min_green[p] == COUNT_MAX)
            begin
                // long quiet stretch drives the counter into saturation
                quiet_run = 270;
                n_items   = 30;
            end
            if (p == 4)
            begin
                set_idle_mode(0);
                fork
                begin
                    hold_off <= 1'b1;
                    repeat (300) @(posedge clk);
                    hold_off <= 1'b0;
                end
                join_none
            end
            for (int k = 0; k < quiet_run; k++)
                send_tick(rand_quiet_code(), 0, tw);
            for (int k = 0; k < n_items; k++)
                send_tick(rand_tick_code(), 0, tw);
        end

        wait_lights_settled();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && light_words_due.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
